// ===== hw/rtl/b64as_pkg.sv =====
// Package for the binary64 adder: constants and helper functions.
package b64as_pkg;

  localparam logic [63:0] SignMask   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QuietMask  = 64'h0008_0000_0000_0000;
  localparam logic [63:0] InfBits    = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DefaultNan = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] ExpMax     = 11'h7FF;
  localparam logic [10:0] HalfUlp    = 11'h400;
  localparam int unsigned TdataInW   = 136;
  localparam int unsigned TdataOutW  = 64;

  typedef struct packed {
    logic        op;
    logic [63:0] a;
    logic [63:0] b;
  } in_item_t;

  // Leading zero count of a 64-bit word (64 when zero).
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    logic       hit;
    n   = 7'd64;
    hit = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 7'(63 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Right shift with sticky OR of the bits shifted out.
  function automatic logic [63:0] sticky_shr(input logic [63:0] v, input logic [12:0] k);
    logic [63:0] r;
    logic [63:0] lost_mask;
    if (k == 13'd0) begin
      r = v;
    end else if (k >= 13'd64) begin
      r = {63'd0, |v};
    end else begin
      lost_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << k[5:0]);
      r = (v >> k[5:0]) | {63'd0, |(v & lost_mask)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/binary64_add_subtract.sv =====
// binary64_add_subtract: IEEE 754 double adder/subtractor, round to nearest even.
// One transfer in, one transfer out per item. The operand pair is captured in an input
// register, the full align/add/normalize/round path sits between that register and the
// result register, and a new pair is taken every cycle unless the result register is
// stalled. The input register loads whenever it is empty or its item moves forward; the
// result register loads whenever it is empty or being drained.
module binary64_add_subtract (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [135:0] s_axis_tdata_i,   // op[0], a[64:1], b[128:65], zero pad
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o    // sum_bits[63:0]
);

  logic                 in_vld_q, out_vld_q;
  b64as_pkg::in_item_t  in_q;
  logic [63:0]          out_q, res_d;
  logic                 out_load, in_load;

  assign out_load        = ~out_vld_q | m_axis_tready_i;
  assign s_axis_tready_o = ~in_vld_q | out_load;
  assign in_load         = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
      if (out_load) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q.op <= s_axis_tdata_i[0];
      in_q.a  <= s_axis_tdata_i[64:1];
      in_q.b  <= s_axis_tdata_i[128:65];
    end
    if (out_load && in_vld_q) out_q <= res_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  logic [63:0] x, y, bb, bx, by, mx, my, sg, m;
  logic        xn, yn, xi, yi, xz, yz;
  logic [10:0] ex_r, ey_r;
  logic [12:0] ex, ey, e;
  logic [6:0]  zx, zy, z;
  logic [53:0] keep;
  logic [10:0] low;
  logic [63:0] packed_bits;

  always_comb begin
    bb = in_q.b;
    if (in_q.op && !((bb & ~b64as_pkg::SignMask) > b64as_pkg::InfBits))
      bb = bb ^ b64as_pkg::SignMask;
    xn = (in_q.a & ~b64as_pkg::SignMask) > b64as_pkg::InfBits;
    yn = (bb & ~b64as_pkg::SignMask) > b64as_pkg::InfBits;
    xi = (in_q.a & ~b64as_pkg::SignMask) == b64as_pkg::InfBits;
    yi = (bb & ~b64as_pkg::SignMask) == b64as_pkg::InfBits;
    xz = in_q.a[62:0] == 63'd0;
    yz = bb[62:0] == 63'd0;
    if (in_q.a[62:0] < bb[62:0]) begin
      x = bb; y = in_q.a;
    end else begin
      x = in_q.a; y = bb;
    end
    ex_r = x[62:52];
    ey_r = y[62:52];
    bx = {1'b0, x[51:0], 11'd0};
    by = {1'b0, y[51:0], 11'd0};
    zx = b64as_pkg::lzc64(bx);
    zy = b64as_pkg::lzc64(by);
    if (ex_r == 11'd0) begin
      mx = bx << zx[5:0];
      ex = 13'd1 - {6'd0, zx};
    end else begin
      mx = {1'b1, x[51:0], 11'd0};
      ex = {2'd0, ex_r};
    end
    if (ey_r == 11'd0) begin
      my = by << zy[5:0];
      ey = 13'd1 - {6'd0, zy};
    end else begin
      my = {1'b1, y[51:0], 11'd0};
      ey = {2'd0, ey_r};
    end
    mx = mx >> 1;
    my = b64as_pkg::sticky_shr(my >> 1, ex - ey);
    sg = (x[63] ^ y[63]) ? mx - my : mx + my;
    z  = b64as_pkg::lzc64(sg);
    m  = sg << z[5:0];
    e  = ex + 13'd1 - {6'd0, z};
    if ($signed(e) < 13'sd1) begin
      m = b64as_pkg::sticky_shr(m, 13'd1 - e);
      e = 13'd1;
    end
    keep = {1'b0, m[63:11]};
    low  = m[10:0];
    if (low > b64as_pkg::HalfUlp || (low == b64as_pkg::HalfUlp && keep[0]))
      keep = keep + 54'd1;
    packed_bits = {1'b0, e[10:0] - 11'd1, 52'd0} + {10'd0, keep};

    if (xn) res_d = in_q.a | b64as_pkg::QuietMask;
    else if (yn) res_d = bb | b64as_pkg::QuietMask;
    else if (xi || yi) begin
      if (xi && yi && (in_q.a[63] ^ bb[63])) res_d = b64as_pkg::DefaultNan;
      else res_d = xi ? in_q.a : bb;
    end else if (xz || yz) begin
      if (xz && yz) res_d = in_q.a & bb & b64as_pkg::SignMask;
      else res_d = xz ? bb : in_q.a;
    end else if (sg == 64'd0) res_d = 64'd0;
    else if ($signed(e) >= $signed({2'd0, b64as_pkg::ExpMax}))
      res_d = {x[63], 63'd0} | b64as_pkg::InfBits;
    else begin
      if (packed_bits[62:52] >= b64as_pkg::ExpMax || packed_bits[63])
        res_d = {x[63], 63'd0} | b64as_pkg::InfBits;
      else res_d = {x[63], packed_bits[62:0]};
    end
  end

  logic unused_pad;
  assign unused_pad = ^s_axis_tdata_i[135:129];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |=> out_vld_q && $stable(out_q))
    else $error("result changed while stalled");
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_load |=> in_vld_q)
    else $error("input stage lost an item");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready_o)
    else $error("empty input stage not ready");

endmodule
